// ===== rtl/mdfs_pkg.sv =====
package mdfs_pkg;

    localparam int POS_W      = 4;
    localparam int ACT_W      = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [ACT_W-1:0] ACT_FWD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GOAL  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STUCK = 2'd3;

    localparam logic [DIR_W-1:0] DIR_N = 2'd0;
    localparam logic [DIR_W-1:0] DIR_E = 2'd1;
    localparam logic [DIR_W-1:0] DIR_S = 2'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = 1'd1;

    localparam logic [POS_W-1:0] GOAL_RESET = 4'd7;

    typedef struct packed {
        logic wall_north;
        logic wall_east;
        logic wall_south;
        logic wall_west;
    } wall_in_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [DIR_W-1:0] move_dir;
        logic [POS_W-1:0] new_x;
        logic [POS_W-1:0] new_y;
    } step_out_t;

    typedef struct packed {
        logic             found;
        logic [DIR_W-1:0] dir;
    } pick_t;

endpackage

// ===== rtl/maze_dfs_explore_step.sv =====
// depth-first maze explorer, one cell step per transfer on the input channel
// in_data carries the four wall bits sensed at the current cell; each input
// transfer yields exactly one out_data transfer: action, move_dir and the
// robot position after the step
// goal_x / goal_y are written over the cfg channel (index 0 and 1, reset 7);
// cfg_ready is always high, writes are meant for idle periods
// each item passes through a read / read / modify-write sequence on the
// visited row memory (rows above and at the robot, then the row below), and
// the next item is started only once the current one has left that sequence
// the input side has its own holding register, so the next item is taken
// while the current one is worked on; a finished result sits in the output
// register, and while the receiver stalls the next item waits at its final
// step until that register is free
// after reset the visited memory is cleared one row per cycle, all GRID_SIDE
// rows, with in_ready low; the route stack starts holding cell 0,0
module maze_dfs_explore_step #(
    parameter int GRID_SIDE   = 16,
    parameter int ROUTE_DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mdfs_pkg::wall_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mdfs_pkg::step_out_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mdfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW  = $clog2(GRID_SIDE);
    localparam int RAW = $clog2(ROUTE_DEPTH);
    localparam int RCW = $clog2(ROUTE_DEPTH + 1);
    localparam int GW  = (CW > mdfs_pkg::POS_W) ? CW : mdfs_pkg::POS_W;
    localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RD1  = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [mdfs_pkg::POS_W-1:0]   goal_x_reg, goal_y_reg;
    logic [CW-1:0]                pos_x_reg, pos_x_next;
    logic [CW-1:0]                pos_y_reg, pos_y_next;
    logic [RCW-1:0]               count_reg, count_next;
    logic                         in_full_reg, in_full_next;
    logic                         out_valid_reg, out_valid_next;
    mdfs_pkg::wall_in_t           in_buf_reg;
    mdfs_pkg::wall_in_t           work_reg;
    mdfs_pkg::step_out_t          out_reg;

    logic [GRID_SIDE-1:0]         visited_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0]         vis_rd0_reg;
    logic [GRID_SIDE-1:0]         vis_rd1_reg;
    logic [GRID_SIDE-1:0]         north_row_reg;
    logic [2*CW-1:0]              route_mem [ROUTE_DEPTH];
    logic [2*CW-1:0]              route_old_reg;
    logic [2*CW-1:0]              route_new_reg;

    logic                         issue;
    logic                         exec_go;
    logic [CW-1:0]                y_up, y_dn, x_rt, x_lf;
    logic [CW-1:0]                vis_rd0_addr;
    logic                         vis_rd0_en;
    logic                         vis_we;
    logic [CW-1:0]                vis_wa;
    logic [GRID_SIDE-1:0]         vis_wd;
    logic                         route_we;
    logic [RAW-1:0]               route_wa;
    logic [2*CW-1:0]              route_wd;
    logic [RCW-1:0]               cnt_m1, cnt_m2;
    logic                         two_plus;
    logic [RAW-1:0]               old_addr, new_addr;
    mdfs_pkg::pick_t              pick;
    logic                         at_goal;
    logic [CW-1:0]                nx, ny;
    logic [GRID_SIDE-1:0]         tgt_row;
    logic [GRID_SIDE-1:0]         tgt_row_set;
    logic [CW-1:0]                ox, oy, tx, ty;
    logic [mdfs_pkg::DIR_W-1:0]   back_dir;
    mdfs_pkg::step_out_t          res;
    logic [mdfs_pkg::ACT_W-1:0]   res_act;
    logic [mdfs_pkg::DIR_W-1:0]   res_dir;

    assign cfg_ready = 1'b1;
    assign in_ready  = !in_full_reg && (state_reg != ST_CLR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign issue   = (state_reg == ST_IDLE) && in_full_reg;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign y_up = (pos_y_reg == LAST) ? pos_y_reg : pos_y_reg + CW'(1);
    assign y_dn = (pos_y_reg == '0) ? pos_y_reg : pos_y_reg - CW'(1);
    assign x_rt = (pos_x_reg == LAST) ? pos_x_reg : pos_x_reg + CW'(1);
    assign x_lf = (pos_x_reg == '0) ? pos_x_reg : pos_x_reg - CW'(1);

    // row above on the first read, row below on the second
    assign vis_rd0_addr = (state_reg == ST_RD1) ? y_dn : y_up;
    assign vis_rd0_en   = issue || (state_reg == ST_RD1);

    assign cnt_m1   = count_reg - RCW'(1);
    assign cnt_m2   = count_reg - RCW'(2);
    assign two_plus = count_reg >= RCW'(2);
    assign old_addr = two_plus ? cnt_m1[RAW-1:0] : '0;
    assign new_addr = two_plus ? cnt_m2[RAW-1:0] : '0;

    mdfs_pick #(
        .GRID_SIDE (GRID_SIDE)
    ) u_pick (
        .walls     (work_reg),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .north_row (north_row_reg),
        .cur_row   (vis_rd1_reg),
        .south_row (vis_rd0_reg),
        .pick      (pick)
    );

    assign at_goal = (GW'(pos_x_reg) == GW'(goal_x_reg)) && (GW'(pos_y_reg) == GW'(goal_y_reg));

    always_comb
    begin
        nx      = pos_x_reg;
        ny      = pos_y_reg;
        tgt_row = vis_rd1_reg;
        unique case (pick.dir)
            mdfs_pkg::DIR_N:
            begin
                ny      = y_up;
                tgt_row = north_row_reg;
            end
            mdfs_pkg::DIR_E:
            begin
                nx = x_rt;
            end
            mdfs_pkg::DIR_S:
            begin
                ny      = y_dn;
                tgt_row = vis_rd0_reg;
            end
            mdfs_pkg::DIR_W_:
            begin
                nx = x_lf;
            end
        endcase
        tgt_row_set     = tgt_row;
        tgt_row_set[nx] = 1'b1;
    end

    assign ox = route_old_reg[CW-1:0];
    assign oy = route_old_reg[2*CW-1:CW];
    assign tx = route_new_reg[CW-1:0];
    assign ty = route_new_reg[2*CW-1:CW];

    // direction of the step back; a non-adjacent top reports north
    always_comb
    begin
        if ((tx == ox) && ({1'b0, ty} == {1'b0, oy} + (CW+1)'(1)))
        begin
            back_dir = mdfs_pkg::DIR_N;
        end
        else if ((ty == oy) && ({1'b0, tx} == {1'b0, ox} + (CW+1)'(1)))
        begin
            back_dir = mdfs_pkg::DIR_E;
        end
        else if ((tx == ox) && ({1'b0, ty} + (CW+1)'(1) == {1'b0, oy}))
        begin
            back_dir = mdfs_pkg::DIR_S;
        end
        else if ((ty == oy) && ({1'b0, tx} + (CW+1)'(1) == {1'b0, ox}))
        begin
            back_dir = mdfs_pkg::DIR_W_;
        end
        else
        begin
            back_dir = mdfs_pkg::DIR_N;
        end
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        count_next = count_reg;
        res_act    = mdfs_pkg::ACT_GOAL;
        res_dir    = mdfs_pkg::DIR_N;
        vis_we     = 1'b0;
        vis_wa     = ny;
        vis_wd     = tgt_row_set;
        route_we   = 1'b0;
        route_wa   = count_reg[RAW-1:0];
        route_wd   = {ny, nx};
        if (state_reg == ST_CLR)
        begin
            vis_we   = 1'b1;
            vis_wa   = clr_cnt_reg;
            vis_wd   = '0;
            route_we = 1'b1;
            route_wa = '0;
            route_wd = '0;
        end
        else if (exec_go && !at_goal)
        begin
            if (pick.found)
            begin
                res_act    = mdfs_pkg::ACT_FWD;
                res_dir    = pick.dir;
                pos_x_next = nx;
                pos_y_next = ny;
                vis_we     = 1'b1;
                if (count_reg < RCW'(ROUTE_DEPTH))
                begin
                    route_we   = 1'b1;
                    count_next = count_reg + RCW'(1);
                end
            end
            else if (!two_plus)
            begin
                res_act    = mdfs_pkg::ACT_STUCK;
                count_next = '0;
            end
            else
            begin
                res_act    = mdfs_pkg::ACT_BACK;
                res_dir    = back_dir;
                count_next = cnt_m1;
                pos_x_next = tx;
                pos_y_next = ty;
            end
        end
        res.action   = res_act;
        res.move_dir = res_dir;
        res.new_x    = mdfs_pkg::POS_W'(pos_x_next);
        res.new_y    = mdfs_pkg::POS_W'(pos_y_next);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign in_full_next   = (in_full_reg && !issue) || (in_valid && in_ready);
    assign out_valid_next = exec_go || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            goal_x_reg    <= mdfs_pkg::GOAL_RESET;
            goal_y_reg    <= mdfs_pkg::GOAL_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            count_reg     <= RCW'(1);
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            count_reg     <= count_next;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mdfs_pkg::REG_GOAL_X: goal_x_reg <= cfg_data;
                    mdfs_pkg::REG_GOAL_Y: goal_y_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_buf_reg <= in_data;
        end
        if (issue)
        begin
            work_reg <= in_buf_reg;
        end
        if (exec_go)
        begin
            out_reg <= res;
        end
    end

    // visited rows: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visited_mem[vis_wa] <= vis_wd;
        end
        if (vis_rd0_en)
        begin
            vis_rd0_reg <= visited_mem[vis_rd0_addr];
        end
        if (issue)
        begin
            vis_rd1_reg <= visited_mem[pos_y_reg];
        end
        if (state_reg == ST_RD1)
        begin
            north_row_reg <= vis_rd0_reg;
        end
    end

    // route stack: old top and the entry below it are read together
    always_ff @(posedge clk)
    begin
        if (route_we)
        begin
            route_mem[route_wa] <= route_wd;
        end
        if (issue)
        begin
            route_old_reg <= route_mem[old_addr];
            route_new_reg <= route_mem[new_addr];
        end
    end

endmodule

// ===== rtl/mdfs_pick.sv =====
module mdfs_pick #(
    parameter int GRID_SIDE = 16
) (
    input  mdfs_pkg::wall_in_t                 walls,
    input  logic [$clog2(GRID_SIDE)-1:0]       pos_x,
    input  logic [$clog2(GRID_SIDE)-1:0]       pos_y,
    input  logic [GRID_SIDE-1:0]               north_row,
    input  logic [GRID_SIDE-1:0]               cur_row,
    input  logic [GRID_SIDE-1:0]               south_row,
    output mdfs_pkg::pick_t                    pick
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

    logic [CW-1:0] x_rt;
    logic [CW-1:0] x_lf;
    logic          open_n;
    logic          open_e;
    logic          open_s;
    logic          open_w;

    // clamp the side indexes so the bit select stays inside the row
    assign x_rt = (pos_x == LAST) ? pos_x : pos_x + CW'(1);
    assign x_lf = (pos_x == '0) ? pos_x : pos_x - CW'(1);

    assign open_n = !walls.wall_north && (pos_y != LAST) && !north_row[pos_y == LAST ? '0 : pos_x];
    assign open_e = !walls.wall_east  && (pos_x != LAST) && !cur_row[x_rt];
    assign open_s = !walls.wall_south && (pos_y != '0)   && !south_row[pos_x];
    assign open_w = !walls.wall_west  && (pos_x != '0)   && !cur_row[x_lf];

    always_comb
    begin
        pick.found = open_n || open_e || open_s || open_w;
        if (open_n)
        begin
            pick.dir = mdfs_pkg::DIR_N;
        end
        else if (open_e)
        begin
            pick.dir = mdfs_pkg::DIR_E;
        end
        else if (open_s)
        begin
            pick.dir = mdfs_pkg::DIR_S;
        end
        else
        begin
            pick.dir = mdfs_pkg::DIR_W_;
        end
    end

endmodule

// ===== rtl/mdfs_checker.sv =====
module mdfs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input mdfs_pkg::step_out_t             out_data
);

    logic [2:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every result belongs to an accepted item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a pending item");

    // input buffer, work slot and output register bound the items in flight
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many items in flight");

    // arrival and stuck report no direction
    a_idle_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.action == mdfs_pkg::ACT_GOAL) ||
                      (out_data.action == mdfs_pkg::ACT_STUCK))
        |-> out_data.move_dir == mdfs_pkg::DIR_N)
        else $error("direction reported without a move");

endmodule

bind maze_dfs_explore_step mdfs_checker u_mdfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
